// ----- sv/ffs_pkg.sv -----
// Shared types and constants for the feeder and fan sequencer.
// Holds the beat payload structs, the configuration index codes and reset values.
// Depends on nothing; every other file refers to it by scoped names.
package ffs_pkg;

    localparam int DUR_W              = 24;
    localparam int TEMP_W             = 8;
    localparam int CFG_IDX_W          = 3;
    localparam int DEFAULT_TIMER_BITS = 24;

    localparam logic [DUR_W-1:0]         FEED_RUN_RESET       = 24'd8000;
    localparam logic [DUR_W-1:0]         FEED_PAUSE_RESET     = 24'd30000;
    localparam logic [DUR_W-1:0]         KEEPALIVE_WAIT_RESET = 24'd1800000;
    localparam logic [DUR_W-1:0]         KEEPALIVE_FAN_RESET  = 24'd10000;
    localparam logic [DUR_W-1:0]         KEEPALIVE_FEED_RESET = 24'd3000;
    localparam logic signed [TEMP_W-1:0] CRITICAL_TEMP_RESET  = 8'sd40;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEED_RUN       = 3'd0,
        REG_FEED_PAUSE     = 3'd1,
        REG_KEEPALIVE_WAIT = 3'd2,
        REG_KEEPALIVE_FAN  = 3'd3,
        REG_KEEPALIVE_FEED = 3'd4,
        REG_CRITICAL_TEMP  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic                     started;
        logic                     burn_requested;
        logic                     manual_feed;
        logic signed [TEMP_W-1:0] feeder_temp;
    } item_t;

    typedef struct packed {
        logic fan_on;
        logic feeder_on;
    } result_t;

    typedef struct packed {
        logic [DUR_W-1:0]         feed_run_ms;
        logic [DUR_W-1:0]         feed_pause_ms;
        logic [DUR_W-1:0]         keepalive_wait_ms;
        logic [DUR_W-1:0]         keepalive_fan_ms;
        logic [DUR_W-1:0]         keepalive_feed_ms;
        logic signed [TEMP_W-1:0] critical_temp;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic clear;
    } timer_ctl_t;

    typedef struct packed {
        logic active;
        logic expire;
    } timer_status_t;

endpackage

// ----- sv/ffs_regs.sv -----
// Configuration register file of the feeder and fan sequencer.
// Six registers written through the configuration channel; uses ffs_pkg.
module ffs_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [ffs_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [ffs_pkg::DUR_W-1:0]     wr_data,
    output ffs_pkg::cfg_t                 cfg
);

    ffs_pkg::cfg_t cfg_reg;
    ffs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                ffs_pkg::REG_FEED_RUN:       cfg_next.feed_run_ms       = wr_data;
                ffs_pkg::REG_FEED_PAUSE:     cfg_next.feed_pause_ms     = wr_data;
                ffs_pkg::REG_KEEPALIVE_WAIT: cfg_next.keepalive_wait_ms = wr_data;
                ffs_pkg::REG_KEEPALIVE_FAN:  cfg_next.keepalive_fan_ms  = wr_data;
                ffs_pkg::REG_KEEPALIVE_FEED: cfg_next.keepalive_feed_ms = wr_data;
                ffs_pkg::REG_CRITICAL_TEMP:
                    cfg_next.critical_temp = wr_data[ffs_pkg::TEMP_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.feed_run_ms       <= ffs_pkg::FEED_RUN_RESET;
            cfg_reg.feed_pause_ms     <= ffs_pkg::FEED_PAUSE_RESET;
            cfg_reg.keepalive_wait_ms <= ffs_pkg::KEEPALIVE_WAIT_RESET;
            cfg_reg.keepalive_fan_ms  <= ffs_pkg::KEEPALIVE_FAN_RESET;
            cfg_reg.keepalive_feed_ms <= ffs_pkg::KEEPALIVE_FEED_RESET;
            cfg_reg.critical_temp     <= ffs_pkg::CRITICAL_TEMP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/ffs_timer.sv -----
// One-shot millisecond timer with saturating elapsed count and expiry compare.
// Advances on each tick; start and clear come from the sequencer; uses ffs_pkg.
module ffs_timer
#(
    parameter int TIMER_BITS = ffs_pkg::DEFAULT_TIMER_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      tick,
    input  logic [ffs_pkg::DUR_W-1:0] dur,
    input  ffs_pkg::timer_ctl_t       ctl,
    output ffs_pkg::timer_status_t    status
);

    localparam int CMP_W = (TIMER_BITS > ffs_pkg::DUR_W) ? TIMER_BITS : ffs_pkg::DUR_W;

    logic                  active_reg;
    logic                  active_next;
    logic [TIMER_BITS-1:0] elapsed_reg;
    logic [TIMER_BITS-1:0] elapsed_next;
    logic [TIMER_BITS-1:0] advanced;
    logic                  expire;

    always_comb
    begin
        advanced = elapsed_reg;
        if (elapsed_reg != {TIMER_BITS{1'b1}})
        begin
            advanced = elapsed_reg + TIMER_BITS'(1);
        end
        expire = active_reg && (CMP_W'(advanced) >= CMP_W'(dur));
    end

    assign status.active = active_reg && !expire;
    assign status.expire = expire;

    always_comb
    begin
        active_next  = active_reg;
        elapsed_next = elapsed_reg;
        if (tick)
        begin
            if (ctl.clear)
            begin
                active_next  = 1'b0;
                elapsed_next = '0;
            end
            else if (ctl.start)
            begin
                active_next  = 1'b1;
                elapsed_next = '0;
            end
            else if (active_reg)
            begin
                active_next  = !expire;
                elapsed_next = expire ? '0 : advanced;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            elapsed_reg <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

// ----- sv/feeder_fan_sequencer.sv -----
// Top level of the feeder and fan sequencer for a coal furnace.
// Instantiates ffs_regs and five ffs_timer units; uses ffs_pkg.
//
// Usage: send one beat on the item channel per millisecond tick, carrying the
// started, burn_requested and manual_feed flags and the feeder temperature.
// Each accepted beat yields exactly one beat on the result channel with the
// fan_on and feeder_on drives for that tick. The channels use valid/ready.
// The result beat is registered, valid in the cycle after the item beat is
// accepted. Throughput is one item per cycle without result stalls, set by
// the single pass through the five timer compares into the result register.
// When the receiver stalls, the result register holds its beat; the item
// channel keeps accepting as long as the held beat is taken in the same cycle.
// The configuration channel is always ready and writes one register per beat;
// indexes beyond the register list are ignored. Write it only while idle.
// Reset clears all timers, restores the default durations and threshold, and
// empties the result register.
module feeder_fan_sequencer
#(
    parameter int TIMER_BITS = ffs_pkg::DEFAULT_TIMER_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  ffs_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output ffs_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ffs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffs_pkg::DUR_W-1:0]     cfg_data
);

    ffs_pkg::cfg_t          cfg;
    ffs_pkg::timer_ctl_t    feed_ctl, pause_ctl, wait_ctl, bfan_ctl, bfeed_ctl;
    ffs_pkg::timer_status_t feed_st, pause_st, wait_st, bfan_st, bfeed_st;

    logic             accept;
    logic             burn_mode;
    logic             keep_mode;
    logic             feed_a, pause_a, wait_a, bfan_a, bfeed_a;
    ffs_pkg::result_t result_next;
    ffs_pkg::result_t result_reg;
    logic             result_valid_reg;
    logic             result_valid_next;

    assign cfg_ready = 1'b1;

    ffs_regs u_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ffs_timer #(.TIMER_BITS(TIMER_BITS)) u_feed
    (
        .clk(clk), .rst_n(rst_n), .tick(accept), .dur(cfg.feed_run_ms),
        .ctl(feed_ctl), .status(feed_st)
    );

    ffs_timer #(.TIMER_BITS(TIMER_BITS)) u_pause
    (
        .clk(clk), .rst_n(rst_n), .tick(accept), .dur(cfg.feed_pause_ms),
        .ctl(pause_ctl), .status(pause_st)
    );

    ffs_timer #(.TIMER_BITS(TIMER_BITS)) u_wait
    (
        .clk(clk), .rst_n(rst_n), .tick(accept), .dur(cfg.keepalive_wait_ms),
        .ctl(wait_ctl), .status(wait_st)
    );

    ffs_timer #(.TIMER_BITS(TIMER_BITS)) u_burst_fan
    (
        .clk(clk), .rst_n(rst_n), .tick(accept), .dur(cfg.keepalive_fan_ms),
        .ctl(bfan_ctl), .status(bfan_st)
    );

    ffs_timer #(.TIMER_BITS(TIMER_BITS)) u_burst_feed
    (
        .clk(clk), .rst_n(rst_n), .tick(accept), .dur(cfg.keepalive_feed_ms),
        .ctl(bfeed_ctl), .status(bfeed_st)
    );

    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    assign burn_mode = item.started && item.burn_requested;
    assign keep_mode = item.started && !item.burn_requested;

    // Activity after advancing and after the expiry chain has started timers.
    assign feed_a  = feed_st.active  || pause_st.expire;
    assign pause_a = pause_st.active || feed_st.expire;
    assign wait_a  = wait_st.active;
    assign bfan_a  = bfan_st.active  || wait_st.expire;
    assign bfeed_a = bfeed_st.active || wait_st.expire;

    always_comb
    begin
        feed_ctl.start  = pause_st.expire || (burn_mode && !feed_a && !pause_a);
        feed_ctl.clear  = !burn_mode;
        pause_ctl.start = feed_st.expire;
        pause_ctl.clear = !burn_mode;
        wait_ctl.start  = keep_mode && !wait_a && !bfan_a && !bfeed_a;
        wait_ctl.clear  = !keep_mode;
        bfan_ctl.start  = wait_st.expire;
        bfan_ctl.clear  = !keep_mode;
        bfeed_ctl.start = wait_st.expire;
        bfeed_ctl.clear = !keep_mode;
    end

    always_comb
    begin
        result_next.fan_on    = 1'b0;
        result_next.feeder_on = 1'b0;
        if (burn_mode)
        begin
            result_next.fan_on    = 1'b1;
            result_next.feeder_on = feed_a || !pause_a;
        end
        else if (keep_mode)
        begin
            result_next.fan_on    = bfan_a;
            result_next.feeder_on = bfeed_a;
        end
        if (item.manual_feed)
        begin
            result_next.feeder_on = 1'b1;
        end
        if (item.feeder_temp > cfg.critical_temp)
        begin
            result_next.feeder_on = 1'b1;
            result_next.fan_on    = 1'b0;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (accept)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for feeder_fan_sequencer: directed and random millisecond ticks.
// Predicts the fan and feeder drives from its own shadow of the five timers and registers.
// Depends on ffs_pkg and the sequencer RTL only.
module tb_top;

    typedef logic [ffs_pkg::DUR_W-1:0]         dur_t;
    typedef logic signed [ffs_pkg::TEMP_W-1:0] temp_t;
    typedef logic [ffs_pkg::CFG_IDX_W-1:0]     cfg_idx_t;

    localparam int       CYCLE_LIMIT  = 400000;
    localparam int       MAX_REPORTS  = 30;
    localparam cfg_idx_t REG_SPARE_LO = 3'd6;
    localparam cfg_idx_t REG_SPARE_HI = 3'd7;
    localparam dur_t     DUR_MAX      = '1;

    typedef enum int {T_FEED, T_PAUSE, T_WAIT, T_BURST_FAN, T_BURST_FEED, N_TIMERS} timer_id_t;
    typedef enum int {CFG_RANDOM, CFG_ALL_MIN, CFG_ALL_MAX} cfg_shape_t;

    typedef struct {
        bit   running;
        dur_t count;
    } timer_state_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    ffs_pkg::item_t    item         = '0;
    logic              result_ready = 1'b0;
    logic              cfg_valid    = 1'b0;
    cfg_idx_t          cfg_index    = '0;
    dur_t              cfg_data     = '0;
    logic              item_ready;
    logic              result_valid;
    logic              cfg_ready;
    ffs_pkg::result_t  result;

    ffs_pkg::cfg_t    shadow_cfg;
    timer_state_t     timers[N_TIMERS];
    ffs_pkg::result_t pending_outputs[$];

    int mismatches      = 0;
    int ticks_sent      = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int settings_used   = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_len        = 0;
    int hold_left       = 0;
    bit hold_go         = 1'b0;

    feeder_fan_sequencer i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic void clear_timer(timer_id_t id);
        timers[id].running = 1'b0;
        timers[id].count   = '0;
    endfunction

    function automatic void start_timer(timer_id_t id);
        timers[id].running = 1'b1;
        timers[id].count   = '0;
    endfunction

    function automatic void reset_shadow();
        shadow_cfg.feed_run_ms       = ffs_pkg::FEED_RUN_RESET;
        shadow_cfg.feed_pause_ms     = ffs_pkg::FEED_PAUSE_RESET;
        shadow_cfg.keepalive_wait_ms = ffs_pkg::KEEPALIVE_WAIT_RESET;
        shadow_cfg.keepalive_fan_ms  = ffs_pkg::KEEPALIVE_FAN_RESET;
        shadow_cfg.keepalive_feed_ms = ffs_pkg::KEEPALIVE_FEED_RESET;
        shadow_cfg.critical_temp     = ffs_pkg::CRITICAL_TEMP_RESET;
        foreach (timers[i])
            clear_timer(timer_id_t'(i));
    endfunction

    // Returns 1 when the timer runs out on this tick; it is then idle.
    function automatic bit tick_timer(timer_id_t id, dur_t limit);
        dur_t next;
        if (!timers[id].running)
            return 1'b0;
        next = timers[id].count;
        if (next != DUR_MAX)
            next++;
        if (next >= limit)
        begin
            clear_timer(id);
            return 1'b1;
        end
        timers[id].count = next;
        return 1'b0;
    endfunction

    function automatic ffs_pkg::result_t predict_outputs(ffs_pkg::item_t it);
        bit               feed_end;
        bit               pause_end;
        bit               wait_end;
        ffs_pkg::result_t r;
        feed_end  = tick_timer(T_FEED, shadow_cfg.feed_run_ms);
        pause_end = tick_timer(T_PAUSE, shadow_cfg.feed_pause_ms);
        wait_end  = tick_timer(T_WAIT, shadow_cfg.keepalive_wait_ms);
        void'(tick_timer(T_BURST_FAN, shadow_cfg.keepalive_fan_ms));
        void'(tick_timer(T_BURST_FEED, shadow_cfg.keepalive_feed_ms));
        if (feed_end)
            start_timer(T_PAUSE);
        if (pause_end)
            start_timer(T_FEED);
        if (wait_end)
        begin
            start_timer(T_BURST_FAN);
            start_timer(T_BURST_FEED);
        end
        r = '0;
        if (!it.started)
        begin
            foreach (timers[i])
                clear_timer(timer_id_t'(i));
        end
        else if (it.burn_requested)
        begin
            if (!timers[T_FEED].running && !timers[T_PAUSE].running)
                start_timer(T_FEED);
            r.fan_on    = 1'b1;
            r.feeder_on = timers[T_FEED].running;
            clear_timer(T_WAIT);
            clear_timer(T_BURST_FAN);
            clear_timer(T_BURST_FEED);
        end
        else
        begin
            if (!timers[T_WAIT].running && !timers[T_BURST_FAN].running
                && !timers[T_BURST_FEED].running)
                start_timer(T_WAIT);
            r.fan_on    = timers[T_BURST_FAN].running;
            r.feeder_on = timers[T_BURST_FEED].running;
            clear_timer(T_FEED);
            clear_timer(T_PAUSE);
        end
        if (it.manual_feed)
            r.feeder_on = 1'b1;
        if ($signed(it.feeder_temp) > $signed(shadow_cfg.critical_temp))
        begin
            r.feeder_on = 1'b1;
            r.fan_on    = 1'b0;
        end
        return r;
    endfunction

    function automatic void apply_reg_write(cfg_idx_t idx, dur_t data);
        case (idx)
            ffs_pkg::REG_FEED_RUN:       shadow_cfg.feed_run_ms       = data;
            ffs_pkg::REG_FEED_PAUSE:     shadow_cfg.feed_pause_ms     = data;
            ffs_pkg::REG_KEEPALIVE_WAIT: shadow_cfg.keepalive_wait_ms = data;
            ffs_pkg::REG_KEEPALIVE_FAN:  shadow_cfg.keepalive_fan_ms  = data;
            ffs_pkg::REG_KEEPALIVE_FEED: shadow_cfg.keepalive_feed_ms = data;
            ffs_pkg::REG_CRITICAL_TEMP:
                shadow_cfg.critical_temp = data[ffs_pkg::TEMP_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at result beat %0d: %s", results_checked, what);
    endtask

    // Results are checked before the item of the same edge is predicted.
    always @(posedge clk)
    begin
        ffs_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_outputs.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = pending_outputs.pop_front();
                    if (result.fan_on !== want.fan_on)
                        report_mismatch($sformatf("fan_on %b, expected %b",
                                                  result.fan_on, want.fan_on));
                    if (result.feeder_on !== want.feeder_on)
                        report_mismatch($sformatf("feeder_on %b, expected %b",
                                                  result.feeder_on, want.feeder_on));
                end
                results_checked++;
            end
            if (item_valid && item_ready)
            begin
                pending_outputs.push_back(predict_outputs(item));
                ticks_sent++;
            end
            if (cfg_valid && cfg_ready)
                apply_reg_write(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_go   = 1'b0;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_tick(ffs_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
    endtask

    task automatic drain_outputs();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, dur_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_config(ffs_pkg::cfg_t c, bit with_spares);
        write_reg(ffs_pkg::REG_FEED_RUN, c.feed_run_ms);
        write_reg(ffs_pkg::REG_FEED_PAUSE, c.feed_pause_ms);
        write_reg(ffs_pkg::REG_KEEPALIVE_WAIT, c.keepalive_wait_ms);
        write_reg(ffs_pkg::REG_KEEPALIVE_FAN, c.keepalive_fan_ms);
        write_reg(ffs_pkg::REG_KEEPALIVE_FEED, c.keepalive_feed_ms);
        write_reg(ffs_pkg::REG_CRITICAL_TEMP,
                  {{(ffs_pkg::DUR_W-ffs_pkg::TEMP_W){c.critical_temp[ffs_pkg::TEMP_W-1]}},
                   c.critical_temp});
        if (with_spares)
        begin
            write_reg(REG_SPARE_LO, dur_t'($urandom));
            write_reg(REG_SPARE_HI, dur_t'($urandom));
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    function automatic ffs_pkg::item_t make_tick(bit s, bit b, bit m, int t);
        ffs_pkg::item_t it;
        it.started        = s;
        it.burn_requested = b;
        it.manual_feed    = m;
        it.feeder_temp    = temp_t'(t);
        return it;
    endfunction

    function automatic dur_t random_duration();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return dur_t'($urandom_range(0, 6));
        if (pick < 80)
            return dur_t'($urandom_range(7, 40));
        if (pick < 93)
            return dur_t'($urandom_range(41, 400));
        if (pick < 97)
            return DUR_MAX;
        return dur_t'($urandom);
    endfunction

    function automatic temp_t random_threshold();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return temp_t'($urandom);
        if (pick < 20)
            return 8'sh80;
        if (pick < 25)
            return 8'sh7F;
        return temp_t'($urandom_range(0, 80) - 20);
    endfunction

    // Mostly at or below the threshold, with some overtemperature and some noise.
    function automatic temp_t random_temp(temp_t crit);
        int v;
        if ($urandom_range(99) < 15)
            return temp_t'($urandom);
        v = int'(crit) + int'($urandom_range(0, 40)) - 36;
        if (v < -128)
            v = -128;
        if (v > 127)
            v = 127;
        return temp_t'(v);
    endfunction

    task automatic test_overrides_at_defaults();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_tick(make_tick(0, 0, 0, -128));
        send_tick(make_tick(0, 0, 1, 0));
        send_tick(make_tick(0, 0, 0, 41));
        send_tick(make_tick(0, 0, 0, 40));
        send_tick(make_tick(1, 1, 0, 0));
        send_tick(make_tick(1, 1, 0, 127));
        send_tick(make_tick(1, 0, 0, -55));
        send_tick(make_tick(1, 0, 1, 125));
        send_tick(make_tick(0, 1, 1, -1));
        drain_outputs();
    endtask

    task automatic test_short_timer_chain();
        ffs_pkg::cfg_t c;
        c.feed_run_ms       = 0;
        c.feed_pause_ms     = 1;
        c.keepalive_wait_ms = 0;
        c.keepalive_fan_ms  = 1;
        c.keepalive_feed_ms = 2;
        c.critical_temp     = 8'sh7F;
        program_config(c, 1'b1);
        repeat (6)
            send_tick(make_tick(1, 1, 0, 127));
        repeat (6)
            send_tick(make_tick(1, 0, 0, 20));
        send_tick(make_tick(0, 0, 0, 20));
        send_tick(make_tick(1, 0, 0, -128));
        drain_outputs();
    endtask

    task automatic test_random_phase(int n_ticks, int send_pct, int recv_pct, cfg_shape_t shape);
        ffs_pkg::cfg_t  c;
        ffs_pkg::item_t it;
        int             sent;
        int             kind;
        int             seg_len;
        bit             burn;
        case (shape)
            CFG_ALL_MIN:
            begin
                c = '0;
                c.critical_temp = 8'sh80;
            end
            CFG_ALL_MAX:
            begin
                c = '1;
                c.critical_temp = 8'sh7F;
            end
            default:
            begin
                c.feed_run_ms       = random_duration();
                c.feed_pause_ms     = random_duration();
                c.keepalive_wait_ms = random_duration();
                c.keepalive_fan_ms  = random_duration();
                c.keepalive_feed_ms = random_duration();
                c.critical_temp     = random_threshold();
            end
        endcase
        program_config(c, shape == CFG_RANDOM);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < n_ticks)
        begin
            kind    = $urandom_range(99);
            seg_len = (kind < 80) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            burn    = 1'($urandom_range(1));
            repeat (seg_len)
            begin
                it.started        = (kind < 80) ? 1'b1 :
                                    (kind < 90) ? 1'b0 : 1'($urandom_range(1));
                it.burn_requested = (kind < 90) ? burn : 1'($urandom_range(1));
                it.manual_feed    = ($urandom_range(99) < 8);
                it.feeder_temp    = random_temp(shadow_cfg.critical_temp);
                send_tick(it);
                sent++;
                if (sent == n_ticks / 2)
                    drain_outputs();
            end
        end
        drain_outputs();
    endtask

    // The receiver holds off long enough for the block to stop taking items.
    task automatic test_result_backpressure();
        ffs_pkg::item_t it;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 80;
        hold_go        = 1'b1;
        for (int k = 0; k < 40; k++)
        begin
            it.started        = 1'b1;
            it.burn_requested = (k < 20);
            it.manual_feed    = ($urandom_range(99) < 8);
            it.feeder_temp    = random_temp(shadow_cfg.critical_temp);
            send_tick(it);
        end
        drain_outputs();
    endtask

    initial
    begin
        reset_shadow();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_overrides_at_defaults();
        test_short_timer_chain();
        test_random_phase(150, 0, 0, CFG_RANDOM);
        test_random_phase(150, 81, 0, CFG_RANDOM);
        test_random_phase(150, 0, 81, CFG_ALL_MIN);
        test_random_phase(150, 31, 31, CFG_RANDOM);
        test_random_phase(100, 81, 0, CFG_ALL_MAX);
        test_random_phase(150, 0, 81, CFG_RANDOM);
        test_result_backpressure();
        drain_outputs();
        repeat (4) @(posedge clk);
        if (pending_outputs.size() != 0)
            report_mismatch("expected result beats never arrived");
        $display("Covered %0d ticks under %0d register settings with sender gaps,",
                 ticks_sent, settings_used);
        $display("receiver stalls and a long hold-off; %0d result beats, %0d register writes.",
                 results_checked, reg_writes);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
